/* rtl/core/sqc_pkg.sv */
package sqc_pkg;

  localparam int CHAR_W          = 21;
  localparam int STACK_DEPTH_DEF = 10;

  // Typographic quotes
  localparam logic [CHAR_W-1:0] CP_LEFT_SINGLE  = 21'h02018;
  localparam logic [CHAR_W-1:0] CP_RIGHT_SINGLE = 21'h02019;
  localparam logic [CHAR_W-1:0] CP_LEFT_DOUBLE  = 21'h0201C;
  localparam logic [CHAR_W-1:0] CP_RIGHT_DOUBLE = 21'h0201D;

  // ASCII marks
  localparam logic [CHAR_W-1:0] CP_BACKTICK = 21'h00060;
  localparam logic [CHAR_W-1:0] CP_APOS     = 21'h00027;
  localparam logic [CHAR_W-1:0] CP_DQUOTE   = 21'h00022;
  localparam logic [CHAR_W-1:0] CP_LT       = 21'h0003C;
  localparam logic [CHAR_W-1:0] CP_GT       = 21'h0003E;

  localparam logic [CHAR_W-1:0] CP_DIGIT_0 = 21'h00030;
  localparam logic [CHAR_W-1:0] CP_DIGIT_9 = 21'h00039;
  localparam logic [CHAR_W-1:0] CP_UPPER_A = 21'h00041;
  localparam logic [CHAR_W-1:0] CP_UPPER_Z = 21'h0005A;
  localparam logic [CHAR_W-1:0] CP_LOWER_A = 21'h00061;
  localparam logic [CHAR_W-1:0] CP_LOWER_Z = 21'h0007A;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DOUBLE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_out;
    logic              nesting_full;
  } out_item_t;

  // One character ready for conversion, with its lookahead class
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              next_alnum;
    logic              last;
  } job_t;

  function automatic kind_t quote_kind(input logic [CHAR_W-1:0] c);
    kind_t k;
    case (c) inside
      CP_BACKTICK, CP_APOS, CP_LEFT_SINGLE, CP_RIGHT_SINGLE: k = KIND_SINGLE;
      CP_DQUOTE, CP_LEFT_DOUBLE, CP_RIGHT_DOUBLE:            k = KIND_DOUBLE;
      default:                                               k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c >= CP_DIGIT_0 && c <= CP_DIGIT_9) ||
           (c >= CP_UPPER_A && c <= CP_UPPER_Z) ||
           (c >= CP_LOWER_A && c <= CP_LOWER_Z);
  endfunction

endpackage

/* rtl/core/sqc_chan_if.sv */
interface sqc_chan_if #(parameter type data_t = logic) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/sqc_hold.sv */
module sqc_hold
  import sqc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sqc_chan_if.sink    chars,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_ready
);

  logic [CHAR_W-1:0] held_char;
  logic              held_valid;
  logic [CHAR_W-1:0] pend_char;
  logic              pend_valid;
  logic              slot_free;
  logic              accept;
  logic [CHAR_W-1:0] c;
  logic              eot;

  assign c          = chars.data.char_in;
  assign eot        = chars.data.end_of_text;
  assign slot_free  = !job_valid || job_ready;
  assign chars.ready = slot_free && !pend_valid;
  assign accept     = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pend_valid <= 1'b0;
      job_valid  <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (pend_valid && slot_free) begin
        // issue the final character that waited behind the held one
        job_valid  <= 1'b1;
        job        <= '{ch: pend_char, next_alnum: 1'b0, last: 1'b1};
        pend_valid <= 1'b0;
      end else if (accept) begin
        if (held_valid) begin
          job_valid <= 1'b1;
          job       <= '{ch: held_char, next_alnum: is_alnum(c), last: 1'b0};
          if (eot) begin
            pend_char  <= c;
            pend_valid <= 1'b1;
            held_valid <= 1'b0;
          end else begin
            held_char <= c;
          end
        end else if (eot) begin
          job_valid <= 1'b1;
          job       <= '{ch: c, next_alnum: 1'b0, last: 1'b1};
        end else begin
          held_char  <= c;
          held_valid <= 1'b1;
        end
      end
    end
  end

  a_pend_not_held: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !held_valid)
    else $error("pending final char while a char is still held");

  a_pend_behind_job: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> job_valid)
    else $error("pending final char without a job ahead of it");

endmodule

/* rtl/core/sqc_conv.sv */
module sqc_conv
  import sqc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_ready,
  sqc_chan_if.source  result
);

  logic                   in_tag;
  logic                   prev_alnum;
  logic [DEPTH_W-1:0]     depth;
  logic [STACK_DEPTH-1:0] stk;       // bit 0 is top of stack, 1 = double

  logic [DEPTH_W-1:0]     depth_next;
  logic                   in_tag_now;
  kind_t                  kind;
  logic                   closing;
  logic                   push;
  logic                   pop;
  logic [CHAR_W-1:0]      res;
  logic                   fire;

  assign job_ready = !result.valid || result.ready;
  assign fire      = job_valid && job_ready;

  always_comb begin
    kind       = quote_kind(job.ch);
    in_tag_now = (job.ch == CP_LT) ? 1'b1 : (job.ch == CP_GT) ? 1'b0 : in_tag;
    closing    = (depth != '0) &&
                 ((kind == KIND_SINGLE && !stk[0]) || (kind == KIND_DOUBLE && stk[0]));
    push       = 1'b0;
    pop        = 1'b0;
    res        = job.ch;
    if (!in_tag_now && kind != KIND_NONE) begin
      if (kind == KIND_SINGLE && prev_alnum && (!closing || job.next_alnum)) begin
        res = CP_RIGHT_SINGLE;
      end else if (closing) begin
        res = (kind == KIND_SINGLE) ? CP_RIGHT_SINGLE : CP_RIGHT_DOUBLE;
        pop = 1'b1;
      end else begin
        res  = (kind == KIND_SINGLE) ? CP_LEFT_SINGLE : CP_LEFT_DOUBLE;
        push = (depth != DEPTH_W'(STACK_DEPTH));
      end
    end
    if (push) begin
      depth_next = depth + DEPTH_W'(1);
    end else if (pop) begin
      depth_next = depth - DEPTH_W'(1);
    end else begin
      depth_next = depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag       <= 1'b0;
      prev_alnum   <= 1'b0;
      depth        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (fire) begin
        result.valid <= 1'b1;
        result.data  <= '{char_out:     res,
                          last_out:     job.last,
                          nesting_full: (depth_next == DEPTH_W'(STACK_DEPTH))};
        if (job.last) begin
          in_tag     <= 1'b0;
          prev_alnum <= 1'b0;
          depth      <= '0;
        end else begin
          in_tag     <= in_tag_now;
          prev_alnum <= is_alnum(job.ch);
          depth      <= depth_next;
        end
      end
    end
  end

  // Quote kinds shift in at the top; entries at or above depth are dead
  always_ff @(posedge clk) begin
    if (fire && push) begin
      stk <= {stk[STACK_DEPTH-2:0], kind == KIND_DOUBLE};
    end else if (fire && pop) begin
      stk <= {stk[STACK_DEPTH-1], stk[STACK_DEPTH-1:1]};
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(STACK_DEPTH))
    else $error("quote stack depth beyond its size");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && job.last |=> depth == '0 && !in_tag && !prev_alnum)
    else $error("end of text did not clear the quote state");

  a_result_follows_job: assert property (@(posedge clk) disable iff (rst)
    fire |=> result.valid && result.data.last_out == $past(job.last))
    else $error("result did not follow the converted job");

endmodule

/* rtl/core/smart_quote_converter_core.sv */
// Smart quote converter core.
//
// chars  (sink):   one Unicode code point per request, with end_of_text on
//                  the last character of a text. A request is taken when
//                  valid and ready are both high.
// result (source): the rewritten code point, last_out on the final
//                  character of the text, and nesting_full when the quote
//                  stack holds STACK_DEPTH open quotes after this character.
//
// Each character is held until the next one arrives, since that character
// decides between apostrophe and closing quote. A held character moves to
// the job register when the next request is taken, then to the result
// register. The final character of a text goes straight to the job
// register when nothing is held; after a held one it waits in a pending
// register. Throughput is one character per cycle while result is ready.
// A final character that arrives while another one is held yields two
// results, so the input stalls while it is pending. The quote stack is a
// shift register, so push and pop finish in the same cycle as the conversion.
//
// Reset clears the held character, tag and quote state, and empties both
// stages. When result stalls, one converted character waits in the result
// register and one more waits in the job register; then chars.ready drops.
module smart_quote_converter_core
  import sqc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sqc_chan_if.sink    chars,
  sqc_chan_if.source  result
);

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  logic job_valid;
  logic job_ready;
  job_t job;

  // Hold one character back and pair it with its lookahead
  sqc_hold u_hold (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  // Rewrite quotes, track tags and the open-quote stack
  sqc_conv #(
    .STACK_DEPTH (STACK_DEPTH),
    .DEPTH_W     (DEPTH_W)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .result    (result)
  );

endmodule

/* tb/sv/smart_quote_converter_core_tb.sv */
`timescale 1ns / 100ps

// Drive the converter with a short table of hand-picked text, then with
// random texts in three traffic phases, and check every result against an
// in-bench model of the quote rewriting.
module smart_quote_converter_core_tb;
  import sqc_pkg::*;

  localparam int NEST_DEPTH      = STACK_DEPTH_DEF;
  // Stop the run if no request moves on either side for this many cycles.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Let late results show up after the last expected one has come.
  localparam int DRAIN_CYCLES    = 20;
  // Long receiver stall in the last phase, so the core fills and holds chars.ready low.
  localparam int HOLD_OFF_CYCLES = 120;

  typedef enum int {
    TEXT_PROSE,
    TEXT_NEST,
    TEXT_NOISE
  } text_style_t;

  // One row of the directed table. Rows with known_out set carry the result
  // typed in by hand; the others are checked against the model alone.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    bit                eot;
    bit                known_out;
    logic [CHAR_W-1:0] out_ch;
    bit                out_full;
  } text_row_t;

  logic clk;
  logic rst;

  sqc_chan_if #(.data_t(in_item_t))  chars_if  ();
  sqc_chan_if #(.data_t(out_item_t)) result_if ();

  smart_quote_converter_core #(
    .STACK_DEPTH(NEST_DEPTH)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  // Idle odds per side, in percent of cycles; the stimulus sets them per phase.
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_off_pending;
  int mismatch_count;
  int idle_streak;

  // Results that the core still owes, oldest first.
  out_item_t expected_chars[$];

  // Model state: the held character, its hand-typed result if any, and the
  // tag and quote-nesting state.
  logic [CHAR_W-1:0]     held_ch;
  bit                    held_valid;
  bit                    held_known;
  logic [CHAR_W-1:0]     held_out_ch;
  bit                    held_out_full;
  bit                    after_alnum;
  bit                    inside_tag;
  int                    open_quotes;
  // 1 = double, 0 = single; only entries below open_quotes are meaningful.
  bit [NEST_DEPTH-1:0]   open_kind;

  // Directed text:
  //   a code point of zero, an apostrophe inside a word, a double quote that
  //   closes after a letter, the largest 21-bit value, a single quote that
  //   closes before a non-letter, a double quote inside a tag, and then
  //   eleven opening quotes so the stack fills and the last one is not pushed.
  text_row_t directed_rows[24] = '{
    '{21'h00000,      1'b0, 1'b1, 21'h00000,      1'b0},
    '{CP_DQUOTE,      1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_LOWER_A,     1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_APOS,        1'b0, 1'b0, 21'h0,          1'b0},
    '{21'h00073,      1'b0, 1'b0, 21'h0,          1'b0},  // 's'
    '{CP_DQUOTE,      1'b0, 1'b0, 21'h0,          1'b0},
    '{21'h1FFFFF,     1'b0, 1'b1, 21'h1FFFFF,     1'b0},
    '{CP_BACKTICK,    1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_UPPER_Z,     1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_RIGHT_SINGLE,1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_LT,          1'b0, 1'b1, CP_LT,          1'b0},
    '{CP_DQUOTE,      1'b0, 1'b1, CP_DQUOTE,      1'b0},
    '{CP_GT,          1'b0, 1'b1, CP_GT,          1'b0},
    '{CP_LEFT_DOUBLE, 1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_LEFT_SINGLE, 1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_DQUOTE,      1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_BACKTICK,    1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_RIGHT_DOUBLE,1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_APOS,        1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_LEFT_DOUBLE, 1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_LEFT_SINGLE, 1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_DQUOTE,      1'b0, 1'b0, 21'h0,          1'b0},
    '{CP_BACKTICK,    1'b0, 1'b1, CP_LEFT_SINGLE, 1'b1},
    '{CP_DQUOTE,      1'b1, 1'b1, CP_LEFT_DOUBLE, 1'b1}
  };

  // Clock and the one reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Model of the rewriting
  // ---------------------------------------------------------------------

  function automatic bit letter_or_digit(input logic [CHAR_W-1:0] c);
    return (c >= CP_DIGIT_0 && c <= CP_DIGIT_9) ||
           (c >= CP_UPPER_A && c <= CP_UPPER_Z) ||
           (c >= CP_LOWER_A && c <= CP_LOWER_Z);
  endfunction

  function automatic kind_t kind_of_char(input logic [CHAR_W-1:0] c);
    if (c == CP_BACKTICK || c == CP_APOS || c == CP_LEFT_SINGLE || c == CP_RIGHT_SINGLE)
      return KIND_SINGLE;
    if (c == CP_DQUOTE || c == CP_LEFT_DOUBLE || c == CP_RIGHT_DOUBLE)
      return KIND_DOUBLE;
    return KIND_NONE;
  endfunction

  // Rewrite one character given the class of the one after it, and update
  // the tag and nesting state.
  task automatic rewrite_quote(input logic [CHAR_W-1:0] c, input bit next_alnum,
                               input bit last, output out_item_t r);
    kind_t             k;
    bit                closing;
    logic [CHAR_W-1:0] res;
    res = c;
    // Tag marks take effect before the quote test, so a quote right after
    // '<' is already inside the tag.
    if (c == CP_LT)
      inside_tag = 1'b1;
    else if (c == CP_GT)
      inside_tag = 1'b0;
    k = kind_of_char(c);
    if (!inside_tag && k != KIND_NONE) begin
      closing = open_quotes > 0 && open_kind[open_quotes-1] == (k == KIND_DOUBLE);
      if (k == KIND_SINGLE && after_alnum && (!closing || next_alnum)) begin
        // Apostrophe: leave the stack alone.
        res = CP_RIGHT_SINGLE;
      end else if (closing) begin
        res = (k == KIND_SINGLE) ? CP_RIGHT_SINGLE : CP_RIGHT_DOUBLE;
        open_quotes--;
      end else begin
        res = (k == KIND_SINGLE) ? CP_LEFT_SINGLE : CP_LEFT_DOUBLE;
        // Full stack: convert but drop the push.
        if (open_quotes < NEST_DEPTH) begin
          open_kind[open_quotes] = (k == KIND_DOUBLE);
          open_quotes++;
        end
      end
    end
    after_alnum    = letter_or_digit(c);
    r.char_out     = res;
    r.last_out     = last;
    r.nesting_full = (open_quotes >= NEST_DEPTH);
  endtask

  task automatic clear_text_state();
    held_ch     = '0;
    held_valid  = 1'b0;
    held_known  = 1'b0;
    after_alnum = 1'b0;
    inside_tag  = 1'b0;
    open_quotes = 0;
    open_kind   = '0;
  endtask

  // Advance the model by one accepted request and queue what it owes.
  task automatic track_request(input in_item_t req, input bit known,
                               input logic [CHAR_W-1:0] out_ch, input bit out_full);
    out_item_t r;
    if (held_valid) begin
      rewrite_quote(held_ch, letter_or_digit(req.char_in), 1'b0, r);
      if (held_known) begin
        r.char_out     = held_out_ch;
        r.nesting_full = held_out_full;
      end
      expected_chars.push_back(r);
    end
    if (req.end_of_text) begin
      // Flush: the last character has no lookahead, then forget everything.
      rewrite_quote(req.char_in, 1'b0, 1'b1, r);
      if (known) begin
        r.char_out     = out_ch;
        r.nesting_full = out_full;
      end
      expected_chars.push_back(r);
      clear_text_state();
    end else begin
      held_ch       = req.char_in;
      held_valid    = 1'b1;
      held_known    = known;
      held_out_ch   = out_ch;
      held_out_full = out_full;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Offer one request, idling first at the sender's odds. Called just after
  // a rising edge; returns just after the edge that took the request.
  task automatic offer_request(input in_item_t req, input bit known,
                               input logic [CHAR_W-1:0] out_ch, input bit out_full);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.data  <= req;
    taken = 1'b0;
    // Sample ready at the falling edge, where nothing is in flux.
    while (!taken) begin
      @(negedge clk);
      taken = chars_if.ready;
      @(posedge clk);
    end
    track_request(req, known, out_ch, out_full);
  endtask

  function automatic logic [CHAR_W-1:0] quote_of(input bit dbl);
    logic [CHAR_W-1:0] c;
    if (dbl) begin
      case ($urandom_range(2))
        0:       c = CP_DQUOTE;
        1:       c = CP_LEFT_DOUBLE;
        default: c = CP_RIGHT_DOUBLE;
      endcase
    end else begin
      case ($urandom_range(3))
        0:       c = CP_BACKTICK;
        1:       c = CP_APOS;
        2:       c = CP_LEFT_SINGLE;
        default: c = CP_RIGHT_SINGLE;
      endcase
    end
    return c;
  endfunction

  // Mostly words, spaces and quotes, with the odd tag and stray code point.
  function automatic logic [CHAR_W-1:0] prose_char();
    int                pick;
    logic [CHAR_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(2))
        0:       c = CHAR_W'(CP_DIGIT_0 + $urandom_range(9));
        1:       c = CHAR_W'(CP_UPPER_A + $urandom_range(25));
        default: c = CHAR_W'(CP_LOWER_A + $urandom_range(25));
      endcase
    end else if (pick < 60) begin
      c = ($urandom_range(1) == 0) ? 21'h00020 : 21'h0002C;  // space or comma
    end else if (pick < 85) begin
      c = quote_of(1'($urandom_range(1)));
    end else if (pick < 89) begin
      c = CP_LT;
    end else if (pick < 93) begin
      c = CP_GT;
    end else begin
      c = CHAR_W'($urandom_range(21'h1FFFFF));
    end
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50)
      return CHAR_W'($urandom_range(21'h1FFFFF));
    if (pick < 75)
      return CHAR_W'($urandom_range(127));
    return quote_of(1'($urandom_range(1)));
  endfunction

  // Send one text; the last character carries end_of_text.
  task automatic send_text(input text_style_t style, input int len);
    in_item_t          req;
    bit                dbl;
    logic [CHAR_W-1:0] c;
    dbl = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      case (style)
        TEXT_PROSE: c = prose_char();
        TEXT_NEST: begin
          // Alternate the kind so each quote opens a new level.
          if ($urandom_range(99) < 85) begin
            dbl = ~dbl;
            c   = quote_of(dbl);
          end else begin
            c = prose_char();
          end
        end
        default: c = noise_char();
      endcase
      req.char_in     = c;
      req.end_of_text = (i == len - 1);
      offer_request(req, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic random_texts(input int quota);
    int          sent;
    int          pick;
    int          len;
    text_style_t style;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        style = TEXT_PROSE;
        len   = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
      end else if (pick < 85) begin
        style = TEXT_NEST;
        len   = $urandom_range(8, 16);
      end else begin
        style = TEXT_NOISE;
        len   = $urandom_range(1, 12);
      end
      send_text(style, len);
      sent += len;
    end
  endtask

  initial begin : stimulus
    in_item_t req;
    chars_if.valid   = 1'b0;
    chars_if.data    = '0;
    hold_off_pending = 1'b0;
    mismatch_count   = 0;
    clear_text_state();

    src_idle_pct = 27;
    snk_idle_pct = 77;
    while (rst !== 1'b0) @(posedge clk);

    foreach (directed_rows[i]) begin
      req.char_in     = directed_rows[i].ch;
      req.end_of_text = directed_rows[i].eot;
      offer_request(req, directed_rows[i].known_out, directed_rows[i].out_ch,
                    directed_rows[i].out_full);
    end

    random_texts(620);

    src_idle_pct = 77;
    snk_idle_pct = 27;
    random_texts(620);

    // Full rate on both sides, after one long receiver stall.
    src_idle_pct     = 0;
    snk_idle_pct     = 0;
    hold_off_pending = 1'b1;
    random_texts(610);

    chars_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left        = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                 input logic [CHAR_W-1:0] want);
    $display("mismatch at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Check results and watch for a hang at the falling edge, where both
  // sides hold the values the next rising edge will see.
  always @(negedge clk) begin : result_check
    out_item_t want;
    if (rst === 1'b0) begin
      if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_streak = 0;
      end else begin
        idle_streak++;
        if (idle_streak >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("result with nothing owed", result_if.data.char_out, '0);
        end else begin
          want = expected_chars.pop_front();
          if (result_if.data.char_out !== want.char_out)
            report_mismatch("char_out", result_if.data.char_out, want.char_out);
          if (result_if.data.last_out !== want.last_out)
            report_mismatch("last_out", result_if.data.last_out, want.last_out);
          if (result_if.data.nesting_full !== want.nesting_full)
            report_mismatch("nesting_full", result_if.data.nesting_full, want.nesting_full);
        end
      end
    end else begin
      idle_streak = 0;
    end
  end

endmodule

/* filelist.f */
rtl/core/sqc_pkg.sv
rtl/core/sqc_chan_if.sv
rtl/core/sqc_hold.sv
rtl/core/sqc_conv.sv
rtl/core/smart_quote_converter_core.sv
tb/sv/smart_quote_converter_core_tb.sv
